// ----- rtl/hgn_pkg.sv -----
// ---------------------------------------------------------------------------
// hgn_pkg
// Shared types, constants and helpers for the 2D hashed gradient noise core.
// ---------------------------------------------------------------------------
package hgn_pkg;

   // Default fraction width of coordinates, frequency and internal values
   localparam int FRAC_BITS_DEF = 16;

   // Output format: signed Q1.16, saturated to +/- 1.0
   localparam int OUT_FRAC  = 16;
   localparam int OUT_W     = 18;
   localparam int OUT_LIMIT = 65536;

   // Register stages from request accept to result strobe
   localparam int PIPE_DEPTH = 8;

   // Corner hash multipliers and shift
   localparam logic [31:0] HASH_MUL_X = 32'd374761393;
   localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
   localparam logic [31:0] HASH_MUL_S = 32'd1442695041;
   localparam logic [31:0] HASH_MUL_F = 32'd1274126177;
   localparam int          HASH_SHIFT = 13;

   // Fade polynomial 6t^5 - 15t^4 + 10t^3 coefficients
   localparam int FADE_A = 6;
   localparam int FADE_B = 15;
   localparam int FADE_C = 10;

   localparam logic [31:0] FREQ_RESET = 32'd65536;

   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEED = 1'b0,
      CSR_FREQ = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      GRAD_POS_X = 2'd0,
      GRAD_NEG_X = 2'd1,
      GRAD_POS_Y = 2'd2,
      GRAD_NEG_Y = 2'd3
   } grad_type;

   // Only the low two bits of the final hash multiply are used, and those
   // depend only on the low two bits of each operand.
   function automatic grad_type hash_pick(input logic [31:0] h);
      logic [31:0] sh;
      logic [1:0]  mix;
      sh  = 32'($signed(h) >>> HASH_SHIFT);
      mix = h[1:0] ^ sh[1:0];
      return grad_type'(2'(mix * HASH_MUL_F[1:0]));
   endfunction

endpackage

// ----- rtl/hgn_fade.sv -----
// ---------------------------------------------------------------------------
// hgn_fade
// Three-stage fade curve 6t^5 - 15t^4 + 10t^3 on an unsigned fraction,
// result clamped to [0, 1], with no stall.
// ---------------------------------------------------------------------------
module hgn_fade
   import hgn_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic [FRAC_BITS-1:0] frac,
   output logic [FRAC_BITS:0]   fade
);

   localparam int F   = FRAC_BITS;
   localparam int AW  = F + 5;          // a = 6t - 15, b, c
   localparam int PW  = AW + F + 1;     // a * t
   localparam int QW  = AW + F + 2;     // t3 * c

   localparam logic signed [AW-1:0] A_OFS   = AW'(FADE_B) <<< F;
   localparam logic signed [AW-1:0] C_OFS   = AW'(FADE_C) <<< F;
   localparam logic signed [PW-1:0] HALF_P  = PW'(1) <<< (F - 1);
   localparam logic [2*F:0]         HALF_S  = (2*F+1)'(1) << (F - 1);
   localparam logic signed [QW-1:0] HALF_Q  = QW'(1) <<< (F - 1);
   localparam logic signed [QW-1:0] ONE_Q   = QW'(1) <<< F;

   // stage A: a*t and t*t
   logic signed [AW-1:0] a_w;
   logic signed [PW-1:0] ab_w;
   logic signed [PW-1:0] b_w;
   logic [2*F:0]         sq_w;
   logic signed [AW-1:0] c_in, c_ff;
   logic [F:0]           t2_in, t2_ff;
   logic [F-1:0]         ta_ff;

   always_comb begin
      a_w   = $signed({5'b0, frac}) * $signed(AW'(FADE_A)) - A_OFS;
      ab_w  = PW'(a_w) * PW'($signed({1'b0, frac}));
      b_w   = (ab_w + HALF_P) >>> F;
      c_in  = AW'(b_w) + C_OFS;
      sq_w  = (2*F+1)'(frac) * (2*F+1)'(frac) + HALF_S;
      t2_in = sq_w[2*F:F];
   end

   always_ff @(posedge clock) begin
      c_ff  <= c_in;
      t2_ff <= t2_in;
      ta_ff <= frac;
   end

   // stage B: t3 = t2 * t
   logic [2*F:0]         cube_w;
   logic [F:0]           t3_in, t3_ff;
   logic signed [AW-1:0] cb_ff;

   always_comb begin
      cube_w = (2*F+1)'(t2_ff) * (2*F+1)'(ta_ff) + HALF_S;
      t3_in  = cube_w[2*F:F];
   end

   always_ff @(posedge clock) begin
      t3_ff <= t3_in;
      cb_ff <= c_ff;
   end

   // stage C: f = t3 * c, clamp to [0, 1]
   logic signed [QW-1:0] fp_w;
   logic signed [QW-1:0] fq_w;
   logic [F:0]           fade_in, fade_ff;

   always_comb begin
      fp_w = QW'($signed({1'b0, t3_ff})) * QW'(cb_ff);
      fq_w = (fp_w + HALF_Q) >>> F;
      if (fq_w < 0) begin
         fade_in = '0;
      end else if (fq_w > ONE_Q) begin
         fade_in = ONE_Q[F:0];
      end else begin
         fade_in = fq_w[F:0];
      end
   end

   always_ff @(posedge clock) begin
      fade_ff <= fade_in;
   end

   assign fade = fade_ff;

endmodule

// ----- rtl/hashed_gradient_noise_2d_core.sv -----
// ---------------------------------------------------------------------------
// hashed_gradient_noise_2d_core
// 2D hashed gradient noise: scale, floor to lattice cell, hash four corners,
// axis-gradient dot products, faded bilinear blend, Q1.16 saturated result.
// ---------------------------------------------------------------------------
// Channel   Ports                                   Handshake
// request   start, busy, req_x_coord, req_y_coord   start & !busy
// result    rsp_valid, rsp_noise_value              rsp_valid, one cycle
// config    csr_we, csr_index, csr_wdata            csr_we, no wait
//
// One request per cycle; each result comes out of the 8-stage arithmetic
// pipeline (scale multiply, hash multiply, hash mix, gradient dot, fade
// wait, two lerp stages, output scaling); the fade multiplies run
// alongside the hash mix, dot and wait stages.
// busy stays low: the pipeline always advances and results are strobed.
// Reset clears the valid bits and sets seed 0, frequency 65536.
// ---------------------------------------------------------------------------
module hashed_gradient_noise_2d_core
   import hgn_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [31:0]          req_x_coord,
   input  logic signed [31:0]          req_y_coord,
   output logic                        rsp_valid,
   output logic signed [OUT_W-1:0]     rsp_noise_value,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [31:0]                 csr_wdata
);

   localparam int F   = FRAC_BITS;
   localparam int NW  = F + 2;          // dot products and blends, +/- 1.0
   localparam int LPW = 2 * F + 6;      // lerp product
   localparam int RW  = F + 2 + OUT_FRAC;

   localparam logic signed [NW-1:0]  ONE_N  = NW'(1) <<< F;
   localparam logic signed [LPW-1:0] HALF_L = LPW'(1) <<< (F - 1);

   // ---------------- configuration ----------------
   logic [31:0] seed_hash_ff, seed_hash_in;
   logic [31:0] freq_ff, freq_in;

   always_comb begin
      seed_hash_in = seed_hash_ff;
      freq_in      = freq_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_SEED: seed_hash_in = csr_wdata * HASH_MUL_S;
            CSR_FREQ: freq_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_hash_ff <= '0;
         freq_ff      <= FREQ_RESET;
      end else begin
         seed_hash_ff <= seed_hash_in;
         freq_ff      <= freq_in;
      end
   end

   // ---------------- valid pipeline ----------------
   logic                  accept;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;

   assign busy   = 1'b0;
   assign accept = start & ~busy;
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- stage 1: scale by frequency ----------------
   logic signed [64:0] mul_x_w, mul_y_w;
   logic signed [63:0] prod_x_ff, prod_y_ff;

   assign mul_x_w = $signed(req_x_coord) * $signed({1'b0, freq_ff});
   assign mul_y_w = $signed(req_y_coord) * $signed({1'b0, freq_ff});

   always_ff @(posedge clock) begin
      prod_x_ff <= mul_x_w[63:0];
      prod_y_ff <= mul_y_w[63:0];
   end

   // ---------------- stage 2: cell, fraction, axis hash terms ----------------
   logic signed [63:0] cell_x_w, cell_y_w;
   logic [31:0]        x0_w, y0_w;
   logic [31:0]        hx0_ff, hy0_ff;
   logic [F-1:0]       fx_ff, fy_ff;

   always_comb begin
      cell_x_w = prod_x_ff >>> (2 * F);
      cell_y_w = prod_y_ff >>> (2 * F);
      x0_w     = cell_x_w[31:0];
      y0_w     = cell_y_w[31:0];
   end

   always_ff @(posedge clock) begin
      hx0_ff <= x0_w * HASH_MUL_X;
      hy0_ff <= y0_w * HASH_MUL_Y;
      fx_ff  <= prod_x_ff[2*F-1:F];
      fy_ff  <= prod_y_ff[2*F-1:F];
   end

   // fade units run alongside stages 3 to 5
   logic [F:0] u_w, v_w;

   hgn_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
      .clock (clock),
      .frac  (fx_ff),
      .fade  (u_w)
   );

   hgn_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
      .clock (clock),
      .frac  (fy_ff),
      .fade  (v_w)
   );

   // ---------------- stage 3: corner hashes ----------------
   logic [31:0]  hx1_w, hy1_w;
   grad_type     g00_ff, g10_ff, g01_ff, g11_ff;
   logic [F-1:0] fx3_ff, fy3_ff;

   always_comb begin
      hx1_w = hx0_ff + HASH_MUL_X;
      hy1_w = hy0_ff + HASH_MUL_Y;
   end

   always_ff @(posedge clock) begin
      g00_ff <= hash_pick(hx0_ff + hy0_ff + seed_hash_ff);
      g10_ff <= hash_pick(hx1_w  + hy0_ff + seed_hash_ff);
      g01_ff <= hash_pick(hx0_ff + hy1_w  + seed_hash_ff);
      g11_ff <= hash_pick(hx1_w  + hy1_w  + seed_hash_ff);
      fx3_ff <= fx_ff;
      fy3_ff <= fy_ff;
   end

   // ---------------- stage 4: gradient dot products ----------------
   function automatic logic signed [NW-1:0] grad_dot(
      input grad_type               g,
      input logic signed [NW-1:0]   dx,
      input logic signed [NW-1:0]   dy
   );
      logic signed [NW-1:0] r;
      case (g)
         GRAD_POS_X: r = dx;
         GRAD_NEG_X: r = -dx;
         GRAD_POS_Y: r = dy;
         GRAD_NEG_Y: r = -dy;
         default:    r = dx;
      endcase
      return r;
   endfunction

   logic signed [NW-1:0] dx0_w, dx1_w, dy0_w, dy1_w;
   logic signed [NW-1:0] n00_ff, n10_ff, n01_ff, n11_ff;
   logic signed [NW-1:0] n00d_ff, n10d_ff, n01d_ff, n11d_ff;

   always_comb begin
      dx0_w = $signed({2'b00, fx3_ff});
      dy0_w = $signed({2'b00, fy3_ff});
      dx1_w = dx0_w - ONE_N;
      dy1_w = dy0_w - ONE_N;
   end

   always_ff @(posedge clock) begin
      n00_ff <= grad_dot(g00_ff, dx0_w, dy0_w);
      n10_ff <= grad_dot(g10_ff, dx1_w, dy0_w);
      n01_ff <= grad_dot(g01_ff, dx0_w, dy1_w);
      n11_ff <= grad_dot(g11_ff, dx1_w, dy1_w);
   end

   // ---------------- stage 5: hold dots until the fade is done ----------------
   always_ff @(posedge clock) begin
      n00d_ff <= n00_ff;
      n10d_ff <= n10_ff;
      n01d_ff <= n01_ff;
      n11d_ff <= n11_ff;
   end

   // ---------------- stage 6: blend along x ----------------
   logic signed [LPW-1:0] lx0_d, lx0_p, lx0_s;
   logic signed [LPW-1:0] lx1_d, lx1_p, lx1_s;
   logic signed [NW-1:0]  nx0_ff, nx1_ff;
   logic [F:0]            v6_ff;

   always_comb begin
      lx0_d = LPW'(n10d_ff) - LPW'(n00d_ff);
      lx0_p = lx0_d * LPW'($signed({1'b0, u_w}));
      lx0_s = LPW'(n00d_ff) + ((lx0_p + HALF_L) >>> F);
      lx1_d = LPW'(n11d_ff) - LPW'(n01d_ff);
      lx1_p = lx1_d * LPW'($signed({1'b0, u_w}));
      lx1_s = LPW'(n01d_ff) + ((lx1_p + HALF_L) >>> F);
   end

   always_ff @(posedge clock) begin
      nx0_ff <= lx0_s[NW-1:0];
      nx1_ff <= lx1_s[NW-1:0];
      v6_ff  <= v_w;
   end

   // ---------------- stage 7: blend along y ----------------
   logic signed [LPW-1:0] ly_d, ly_p, ly_s;
   logic signed [NW-1:0]  r_ff;

   always_comb begin
      ly_d = LPW'(nx1_ff) - LPW'(nx0_ff);
      ly_p = ly_d * LPW'($signed({1'b0, v6_ff}));
      ly_s = LPW'(nx0_ff) + ((ly_p + HALF_L) >>> F);
   end

   always_ff @(posedge clock) begin
      r_ff <= ly_s[NW-1:0];
   end

   // ---------------- stage 8: rescale to Q1.16 and saturate ----------------
   localparam logic signed [RW-1:0] LIMIT_P = RW'(OUT_LIMIT);
   localparam logic signed [RW-1:0] LIMIT_N = -RW'(OUT_LIMIT);

   logic signed [RW-1:0]    r_ext, r_scl;
   logic signed [OUT_W-1:0] noise_in, noise_ff;

   assign r_ext = RW'(r_ff);

   generate
      if (FRAC_BITS > OUT_FRAC) begin : g_down
         localparam int DN = FRAC_BITS - OUT_FRAC;
         localparam logic signed [RW-1:0] HALF_DN = RW'(1) <<< (DN - 1);
         assign r_scl = (r_ext + HALF_DN) >>> DN;
      end else if (FRAC_BITS < OUT_FRAC) begin : g_up
         assign r_scl = r_ext <<< (OUT_FRAC - FRAC_BITS);
      end else begin : g_same
         assign r_scl = r_ext;
      end
   endgenerate

   always_comb begin
      if (r_scl > LIMIT_P) begin
         noise_in = OUT_W'(LIMIT_P);
      end else if (r_scl < LIMIT_N) begin
         noise_in = OUT_W'(LIMIT_N);
      end else begin
         noise_in = r_scl[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      noise_ff <= noise_in;
   end

   assign rsp_valid       = vld_ff[PIPE_DEPTH-1];
   assign rsp_noise_value = noise_ff;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2D hashed gradient noise core. A queue of
// sample points feeds a clocked driver. Each accepted request is scored by a
// bit-accurate noise predictor. A monitor compares every strobed result,
// in order, with the oldest prediction. Phases sweep seed, frequency and
// sender idle rate.
// ---------------------------------------------------------------------------
module tb_top;
   import hgn_pkg::*;

   localparam int FRAC        = FRAC_BITS_DEF;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } sample_point_type;

   typedef struct packed {
      sample_point_type        point;
      logic signed [OUT_W-1:0] noise;
   } noise_expect_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [31:0]       req_x_coord = '0;
   logic signed [31:0]       req_y_coord = '0;
   logic                     rsp_valid;
   logic signed [OUT_W-1:0]  rsp_noise_value;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [31:0]              csr_wdata = '0;

   // predictor copy of the configuration registers
   logic [31:0]              noise_seed = 32'd0;
   logic [31:0]              noise_freq = FREQ_RESET;

   sample_point_type         pending_points[$];
   noise_expect_type         noise_expected[$];
   sample_point_type         next_point;
   noise_expect_type         oldest;
   int                       sender_idle_pct = 0;
   int                       n_queued = 0;
   int                       n_accepted = 0;
   int                       n_checked = 0;
   int                       n_settings = 1;
   int                       error_count = 0;
   int                       cycle_count = 0;

   hashed_gradient_noise_2d_core #(
      .FRAC_BITS(FRAC)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .rsp_valid       (rsp_valid),
      .rsp_noise_value (rsp_noise_value),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------- noise predictor ----------------

   // product rescale: add half, then arithmetic shift
   function automatic longint round_down_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint fade_curve(longint t);
      longint one, a, c, t3, f;
      one = longint'(1) <<< FRAC;
      a   = 6 * t - 15 * one;
      c   = round_down_shift(a * t, FRAC) + 10 * one;
      t3  = round_down_shift(round_down_shift(t * t, FRAC) * t, FRAC);
      f   = round_down_shift(t3 * c, FRAC);
      if (f < 0) f = 0;
      if (f > one) f = one;
      return f;
   endfunction

   function automatic grad_type corner_gradient(logic [31:0] cx, logic [31:0] cy);
      logic [31:0]        h;
      logic signed [31:0] hs;
      h  = cx * HASH_MUL_X + cy * HASH_MUL_Y + noise_seed * HASH_MUL_S;
      hs = h;
      hs = hs >>> HASH_SHIFT;
      h  = (h ^ hs) * HASH_MUL_F;
      return grad_type'(h[1:0]);
   endfunction

   function automatic longint corner_dot(logic [31:0] cx, logic [31:0] cy,
                                         longint dx, longint dy);
      case (corner_gradient(cx, cy))
         GRAD_POS_X: return dx;
         GRAD_NEG_X: return -dx;
         GRAD_POS_Y: return dy;
         default:    return -dy;
      endcase
   endfunction

   function automatic longint blend(longint p, longint q, longint w);
      return p + round_down_shift((q - p) * w, FRAC);
   endfunction

   function automatic logic signed [OUT_W-1:0] predict_noise(sample_point_type pt);
      longint      one, xs, ys, xcell, ycell, fx, fy, u, v;
      longint      n00, n10, n01, n11, r;
      logic [31:0] x0, y0, x1, y1;
      one   = longint'(1) <<< FRAC;
      xs    = (longint'(pt.x) * longint'({32'd0, noise_freq})) >>> FRAC;
      ys    = (longint'(pt.y) * longint'({32'd0, noise_freq})) >>> FRAC;
      xcell = xs >>> FRAC;
      ycell = ys >>> FRAC;
      // only the low 32 bits of the cell enter the hash
      x0    = xcell[31:0];
      y0    = ycell[31:0];
      x1    = x0 + 32'd1;
      y1    = y0 + 32'd1;
      fx    = xs & (one - 1);
      fy    = ys & (one - 1);
      u     = fade_curve(fx);
      v     = fade_curve(fy);
      n00   = corner_dot(x0, y0, fx, fy);
      n10   = corner_dot(x1, y0, fx - one, fy);
      n01   = corner_dot(x0, y1, fx, fy - one);
      n11   = corner_dot(x1, y1, fx - one, fy - one);
      r     = blend(blend(n00, n10, u), blend(n01, n11, u), v);
      if (FRAC > OUT_FRAC)
         r = round_down_shift(r, FRAC - OUT_FRAC);
      else if (FRAC < OUT_FRAC)
         r = r <<< (OUT_FRAC - FRAC);
      if (r > OUT_LIMIT) r = OUT_LIMIT;
      if (r < -OUT_LIMIT) r = -OUT_LIMIT;
      return r[OUT_W-1:0];
   endfunction

   // ---------------- request driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            noise_expected.push_back({req_x_coord, req_y_coord,
                                      predict_noise({req_x_coord, req_y_coord})});
            n_accepted++;
         end
         // hold the request while the core reports busy
         if (!(start && busy)) begin
            if (pending_points.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_point = pending_points.pop_front();
               start       <= 1'b1;
               req_x_coord <= next_point.x;
               req_y_coord <= next_point.y;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------- result monitor ----------------

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (noise_expected.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result noise=%0d", $time, rsp_noise_value);
         end else begin
            oldest = noise_expected.pop_front();
            n_checked++;
            if (rsp_noise_value !== oldest.noise) begin
               error_count++;
               $display("%0t: noise mismatch at x=%h y=%h: expected %0d, actual %0d",
                        $time, oldest.point.x, oldest.point.y, oldest.noise,
                        rsp_noise_value);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  noise_expected.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------- stimulus ----------------

   task automatic queue_request(logic [31:0] x, logic [31:0] y);
      pending_points.push_back({x, y});
      n_queued++;
   endtask

   // wait until every queued request is accepted and answered
   task automatic drain();
      while (n_accepted != n_queued || noise_expected.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SEED)
         noise_seed = value;
      else
         noise_freq = value;
   endtask

   function automatic logic [31:0] random_coord();
      logic [15:0] frac;
      case ($urandom_range(3))
         0: return $urandom_range(32'h001FFFFF) - 32'h00100000;
         1: begin
            case ($urandom_range(3))
               0: frac = 16'h0000;
               1: frac = 16'hFFFF;
               2: frac = 16'h8000;
               default: frac = 16'h0001;
            endcase
            return {16'($urandom), frac};
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic run_phase(logic [31:0] seed_val, logic [31:0] freq_val,
                            int idle_pct, int count);
      write_reg(CSR_SEED, seed_val);
      write_reg(CSR_FREQ, freq_val);
      n_settings++;
      sender_idle_pct = idle_pct;
      repeat (count) queue_request(random_coord(), random_coord());
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // lattice points, fraction edges, extremes and cells on both sides of zero
      queue_request(32'h00000000, 32'h00000000);
      queue_request(32'h7FFFFFFF, 32'h7FFFFFFF);
      queue_request(32'h80000000, 32'h80000000);
      queue_request(32'h80000000, 32'h7FFFFFFF);
      queue_request(32'hFFFFFFFF, 32'hFFFFFFFF);
      queue_request(32'h00000001, 32'h00000001);
      queue_request(32'h00008000, 32'h00008000);
      queue_request(32'h00010000, 32'h00020000);
      queue_request(32'h0000FFFF, 32'h0000FFFF);
      queue_request(32'hFFFF8000, 32'h00018000);
      queue_request(32'hFFFF0000, 32'hFFFF0000);
      queue_request(32'h7FFF0000, 32'h00010000);
      queue_request(32'h00004000, 32'h0000C000);
      queue_request(32'h7FFFFFFF, 32'h80000000);
      queue_request(32'h55555555, 32'hAAAAAAAA);
      queue_request(32'hAAAAAAAA, 32'h55555555);
      repeat (120) queue_request(random_coord(), random_coord());
      drain();

      run_phase(32'h7FFFFFFF, 32'hFFFFFFFF, 46, 130);
      run_phase(32'h80000000, 32'h00000000, 29, 130);
      run_phase(32'hFFFFFFFF, 32'h00000001, 0, 130);
      run_phase($urandom, $urandom_range(32'h00040000, 32'h00000100), 46, 130);
      run_phase($urandom, $urandom, 29, 130);
      run_phase(32'h00000000, FREQ_RESET, 46, 130);

      // catch any stray result after the last one expected
      repeat (PIPE_DEPTH + 4) @(posedge clock);

      $display("Run covered %0d noise samples under %0d seed/frequency settings,",
               n_checked, n_settings);
      $display("sender idle at 0, 29 and 46 percent; %0d mismatches", error_count);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
